>>> hdl/drc_pkg.sv
// drift rate correction package: types, register indexes, reset values
// and the controller state encoding
// no dependencies
package drc_pkg;

  // field widths
  localparam int DRIFT_W    = 24;
  localparam int FACTOR_W   = 17;
  localparam int THR_W      = 16;
  localparam int TDATA_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // divider geometry: dividend magnitude stays below 2^32, quotient at most 1.0
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = 16;
  localparam int DIV_Q_W   = 17;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  // 1.0 in Q1.16
  localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CORR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CORR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GN = 3'd4;

  // register reset values
  localparam logic [THR_W-1:0]    RST_DEADBAND  = 16'd2560;
  localparam logic [THR_W-1:0]    RST_SEEK_LIM  = 16'd12800;
  localparam logic [FACTOR_W-1:0] RST_MAX_CORR  = 17'd67502;
  localparam logic [FACTOR_W-1:0] RST_MIN_CORR  = 17'd63570;
  localparam logic [FACTOR_W-1:0] RST_SMOOTH_GN = 17'd6554;

  typedef struct packed {
    logic [THR_W-1:0]    deadband_threshold;
    logic [THR_W-1:0]    seek_limit;
    logic [FACTOR_W-1:0] max_corr;
    logic [FACTOR_W-1:0] min_corr;
    logic [FACTOR_W-1:0] smoothing_gain;
  } drc_cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } drc_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
    logic               rem_nz;
  } drc_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MUL_BAND,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SMOOTH,
    ST_CLAMP,
    ST_DONE
  } drc_state_t;

endpackage

>>> hdl/drc_cfg_regs.sv
// configuration register file for the drift rate correction block
// depends on drc_pkg
module drc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [drc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [drc_pkg::CFG_DATA_W-1:0]   wr_data,
  output drc_pkg::drc_cfg_t                cfg
);

  drc_pkg::drc_cfg_t cfg_r;
  drc_pkg::drc_cfg_t cfg_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        drc_pkg::REG_DEADBAND: begin
          cfg_nxt.deadband_threshold = wr_data[drc_pkg::THR_W-1:0];
        end
        drc_pkg::REG_SEEK_LIM: begin
          cfg_nxt.seek_limit = wr_data[drc_pkg::THR_W-1:0];
        end
        drc_pkg::REG_MAX_CORR: begin
          cfg_nxt.max_corr = wr_data;
        end
        drc_pkg::REG_MIN_CORR: begin
          cfg_nxt.min_corr = wr_data;
        end
        drc_pkg::REG_SMOOTH_GN: begin
          cfg_nxt.smoothing_gain = wr_data;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_threshold <= drc_pkg::RST_DEADBAND;
      cfg_r.seek_limit         <= drc_pkg::RST_SEEK_LIM;
      cfg_r.max_corr           <= drc_pkg::RST_MAX_CORR;
      cfg_r.min_corr           <= drc_pkg::RST_MIN_CORR;
      cfg_r.smoothing_gain     <= drc_pkg::RST_SMOOTH_GN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/drc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on drc_pkg
module drc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  drc_pkg::drc_div_req_t req,
  output drc_pkg::drc_div_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [drc_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [drc_pkg::DIV_D_W-1:0]     rem_r, rem_nxt;
  logic [drc_pkg::DIV_N_W-1:0]     quo_r, quo_nxt;
  logic [drc_pkg::DIV_D_W-1:0]     dvs_r, dvs_nxt;
  logic [drc_pkg::DIV_D_W:0]       rem_sh;
  logic [drc_pkg::DIV_D_W:0]       rem_sub;
  logic                            fits;

  // one shift and trial subtract
  assign rem_sh  = {rem_r, quo_r[drc_pkg::DIV_N_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign fits    = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[drc_pkg::DIV_D_W-1:0] : rem_sh[drc_pkg::DIV_D_W-1:0];
      quo_nxt = {quo_r[drc_pkg::DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == drc_pkg::DIV_CNT_W'(drc_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[drc_pkg::DIV_Q_W-1:0];
  assign rsp.rem_nz   = |rem_r;

endmodule

>>> hdl/av_drift_rate_correction.sv
// audio/video drift rate correction, top level: sequencer, shared multiplier
// depends on drc_pkg, drc_cfg_regs, drc_div
//
//  channel | dir | handshake                | payload
//  in      | in  | in_tvalid / in_tready    | in_tdata: drift
//  out     | out | out_tvalid / out_tready  | out_tdata: rate_factor, active, seek_needed
//  cfg     | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one item at a time: no new drift is taken until the last one is done. Inside the correction
// band the 32-step serial divider sets the pace (it is skipped when the band product is
// zero); the dead band skips the multiply and divide, and a flagged seek skips smoothing too.
// the single 19x18 multiplier serves both the band mapping and the smoothing.
// synchronous active-low reset; factor returns to 1.0.
// a finished result waits in the output register while the next item is taken;
// the sequencer holds in its last state only if that register is still full.
module av_drift_rate_correction (
  input  logic                              clk,
  input  logic                              rst_n,
  // drift [23:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [drc_pkg::TDATA_W-1:0]       in_tdata,
  // rate_factor [16:0], active [17], seek_needed [18], zero [23:19]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [drc_pkg::TDATA_W-1:0]       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic signed [18:0] ONE_S19 = 19'sd65536;

  drc_pkg::drc_cfg_t     cfg;
  drc_pkg::drc_div_req_t div_req;
  drc_pkg::drc_div_rsp_t div_rsp;

  drc_pkg::drc_state_t   state_r, state_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [drc_pkg::FACTOR_W-1:0]         factor_r, factor_nxt;
  logic [drc_pkg::DRIFT_W-1:0]          drift_r, drift_nxt;
  logic                                 pos_r, pos_nxt;
  logic                                 act_r, act_nxt;
  logic                                 seek_r, seek_nxt;
  logic [drc_pkg::THR_W-1:0]            diff_r, diff_nxt;
  logic signed [17:0]                   range_r, range_nxt;
  logic signed [36:0]                   prod_r, prod_nxt;
  logic signed [18:0]                   target_r, target_nxt;
  logic [drc_pkg::FACTOR_W-1:0]         nf_r, nf_nxt;
  logic [drc_pkg::FACTOR_W-1:0]         out_factor_r, out_factor_nxt;
  logic                                 out_act_r, out_act_nxt;
  logic                                 out_seek_r, out_seek_nxt;

  logic signed [18:0]                   mul_a;
  logic signed [17:0]                   mul_b;
  logic signed [36:0]                   mul_p;

  logic [drc_pkg::DRIFT_W-1:0]          mag;
  logic signed [36:0]                   prod_abs;
  logic [18:0]                          quo_ext;
  logic signed [18:0]                   amount;
  logic signed [19:0]                   nf_raw;
  logic signed [19:0]                   nf_lo;
  logic signed [19:0]                   min_s20;
  logic signed [19:0]                   max_s20;

  drc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  drc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // drift magnitude, 24 bits unsigned holds the most negative value too
  assign mag = drift_r[drc_pkg::DRIFT_W-1] ? (~drift_r + 1'b1) : drift_r;

  // floor quotient of the band product: negative side rounds away from zero
  assign prod_abs = prod_r[36] ? (37'sd0 - prod_r) : prod_r;
  assign quo_ext  = {2'b00, div_rsp.quotient};
  assign amount   = prod_r[36] ? $signed(19'd0 - (quo_ext + {18'd0, div_rsp.rem_nz}))
                               : $signed(quo_ext);

  // smoothing step, product shifted down by 16 (floor)
  assign nf_raw  = $signed({3'b000, factor_r}) + prod_r[35:16];
  assign min_s20 = $signed({3'b000, cfg.min_corr});
  assign max_s20 = $signed({3'b000, cfg.max_corr});

  // lower bound applied first
  assign nf_lo = (nf_raw < min_s20) ? min_s20 : nf_raw;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r & ~out_tready;
    factor_nxt       = factor_r;
    drift_nxt        = drift_r;
    pos_nxt          = pos_r;
    act_nxt          = act_r;
    seek_nxt         = seek_r;
    diff_nxt         = diff_r;
    range_nxt        = range_r;
    prod_nxt         = prod_r;
    target_nxt       = target_r;
    nf_nxt           = nf_r;
    out_factor_nxt   = out_factor_r;
    out_act_nxt      = out_act_r;
    out_seek_nxt     = out_seek_r;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_abs[drc_pkg::DIV_N_W-1:0];
    div_req.divisor  = cfg.seek_limit - cfg.deadband_threshold;
    in_tready        = 1'b0;

    case (state_r)
      drc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          drift_nxt = in_tdata[drc_pkg::DRIFT_W-1:0];
          state_nxt = drc_pkg::ST_CLASSIFY;
        end
      end
      drc_pkg::ST_CLASSIFY: begin
        pos_nxt = ~drift_r[drc_pkg::DRIFT_W-1] && (drift_r != '0);
        if (mag < {8'd0, cfg.deadband_threshold}) begin
          // dead band: aim at 1.0
          target_nxt = ONE_S19;
          act_nxt    = 1'b0;
          seek_nxt   = 1'b0;
          state_nxt  = drc_pkg::ST_SMOOTH;
        end else if (mag > {8'd0, cfg.seek_limit}) begin
          // too far off: keep the factor and ask for a seek
          act_nxt   = 1'b0;
          seek_nxt  = 1'b1;
          state_nxt = drc_pkg::ST_DONE;
        end else begin
          act_nxt   = 1'b1;
          seek_nxt  = 1'b0;
          diff_nxt  = mag[drc_pkg::THR_W-1:0] - cfg.deadband_threshold;
          range_nxt = pos_nxt ? ($signed({1'b0, cfg.max_corr}) - 18'sd65536)
                              : (18'sd65536 - $signed({1'b0, cfg.min_corr}));
          state_nxt = drc_pkg::ST_MUL_BAND;
        end
      end
      drc_pkg::ST_MUL_BAND: begin
        mul_a     = $signed({3'b000, diff_r});
        mul_b     = range_r;
        prod_nxt  = mul_p;
        state_nxt = drc_pkg::ST_DIV_START;
      end
      drc_pkg::ST_DIV_START: begin
        if (prod_r == '0) begin
          // zero offset or zero correction range: no correction
          target_nxt = ONE_S19;
          state_nxt  = drc_pkg::ST_SMOOTH;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = drc_pkg::ST_DIV_WAIT;
        end
      end
      drc_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          target_nxt = pos_r ? (ONE_S19 + amount) : (ONE_S19 - amount);
          state_nxt  = drc_pkg::ST_SMOOTH;
        end
      end
      drc_pkg::ST_SMOOTH: begin
        mul_a     = target_r - $signed({2'b00, factor_r});
        mul_b     = $signed({1'b0, cfg.smoothing_gain});
        prod_nxt  = mul_p;
        state_nxt = drc_pkg::ST_CLAMP;
      end
      drc_pkg::ST_CLAMP: begin
        // lower bound first, upper bound wins when the limits cross
        if (nf_lo > max_s20) begin
          nf_nxt = cfg.max_corr;
        end else begin
          nf_nxt = nf_lo[drc_pkg::FACTOR_W-1:0];
        end
        state_nxt = drc_pkg::ST_DONE;
      end
      drc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = seek_r ? factor_r : nf_r;
          out_act_nxt    = act_r;
          out_seek_nxt   = seek_r;
          if (!seek_r) begin
            factor_nxt = nf_r;
          end
          state_nxt = drc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = drc_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      factor_r    <= drc_pkg::ONE_Q16;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      factor_r    <= factor_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    drift_r      <= drift_nxt;
    pos_r        <= pos_nxt;
    act_r        <= act_nxt;
    seek_r       <= seek_nxt;
    diff_r       <= diff_nxt;
    range_r      <= range_nxt;
    prod_r       <= prod_nxt;
    target_r     <= target_nxt;
    nf_r         <= nf_nxt;
    out_factor_r <= out_factor_nxt;
    out_act_r    <= out_act_nxt;
    out_seek_r   <= out_seek_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_seek_r, out_act_r, out_factor_r};

endmodule
